// File: sv/cfa_pkg.sv
// Shared types and constants for the contiguous fit allocator.
`default_nettype none
package cfa_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_MEM_SIZE = 1'b1;

    localparam logic [10:0] MEM_SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic        operation;
        logic [10:0] amount;
        logic [9:0]  position;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [9:0] start_res;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic valid;
        logic is_free;
    } t_run_ctl;

    typedef struct packed {
        logic have;
        logic stop;
    } t_run_sts;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FILL,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

// File: sv/contiguous_fit_allocator.sv
// Contiguous fit allocator: sequencer over the occupancy map and the run tracker.
//
// Input channel (i_valid, o_stall, i_data) carries allocate and release
// requests; output channel (o_valid, i_stall, o_data) returns one result per
// request. The user writes fit mode and memory size through the APB-style port
// only while the block is idle; the block itself does not enforce this.
// After reset the block sweeps the map clear, one unit per cycle, over all
// MEM_UNITS units with o_stall high; configuration writes are taken then.
// One request is in flight at a time; o_stall stays high until its result
// transfers.
// Allocate: scan the units in use through the single map read port and pick
// the run (first fit stops at the first adequate run), then mark the run
// through the map write port, then offer the result in ST_OUT.
// Release: clear amount units from the position through the map write port,
// stopping at the end of the units in use, then offer the result in ST_OUT.
// Allocate with amount zero offers its result the cycle after the transfer.
// A stalled result stays in the output register; nothing else moves until it
// transfers.
`default_nettype none
module contiguous_fit_allocator #(
    parameter int MEM_UNITS = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire cfa_pkg::t_in_item          i_data,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output cfa_pkg::t_out_item              o_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cfa_pkg::CFG_AW-1:0] paddr,
    input  wire logic [cfa_pkg::CFG_DW-1:0] pwdata,
    output logic      [cfa_pkg::CFG_DW-1:0] prdata,
    output logic                            pready
);
    import cfa_pkg::*;

    localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
    localparam int CW = AW + 1;
    localparam int LW = (CW > 11) ? CW : 11;

    t_state        r_state, n_state;
    logic [10:0]   r_amount, n_amount;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_issue_done, n_issue_done;
    logic          r_pv, n_pv;
    logic [CW-1:0] r_pidx, n_pidx;
    logic          r_pterm, n_pterm;
    logic [LW-1:0] r_ptr, n_ptr;
    logic [10:0]   r_cnt, n_cnt;
    logic          r_fill_bit, n_fill_bit;
    logic          r_found, n_found;
    logic [9:0]    r_start, n_start;
    logic [AW-1:0] r_clr, n_clr;

    logic [1:0]    w_fit_mode;
    logic [10:0]   w_mem_size;
    logic [CW-1:0] w_units;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_wdata;
    logic [AW-1:0] w_raddr;
    logic          w_rdata;
    t_run_ctl      w_ctl;
    t_run_sts      w_sts;
    logic [CW-1:0] w_best_start;

    cfa_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_fit_mode (w_fit_mode),
        .o_mem_size (w_mem_size)
    );

    cfa_map #(
        .DEPTH (MEM_UNITS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cfa_run #(
        .CW (CW)
    ) u_run (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_idx        (r_pidx),
        .i_amount     (r_amount),
        .i_mode       (w_fit_mode),
        .o_sts        (w_sts),
        .o_best_start (w_best_start)
    );

    assign w_units = (LW'(w_mem_size) > LW'(MEM_UNITS)) ? CW'(MEM_UNITS) : CW'(w_mem_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pv    <= n_pv;
        end
        r_amount     <= n_amount;
        r_idx        <= n_idx;
        r_issue_done <= n_issue_done;
        r_pidx       <= n_pidx;
        r_pterm      <= n_pterm;
        r_ptr        <= n_ptr;
        r_cnt        <= n_cnt;
        r_fill_bit   <= n_fill_bit;
        r_found      <= n_found;
        r_start      <= n_start;
    end

    always_comb begin
        n_state      = r_state;
        n_amount     = r_amount;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_pv         = r_pv;
        n_pidx       = r_pidx;
        n_pterm      = r_pterm;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_fill_bit   = r_fill_bit;
        n_found      = r_found;
        n_start      = r_start;
        n_clr        = r_clr;
        w_we         = 1'b0;
        w_waddr      = r_ptr[AW-1:0];
        w_wdata      = r_fill_bit;
        w_raddr      = r_idx[AW-1:0];
        w_ctl        = '0;
        w_ctl.is_free = !r_pterm && !w_rdata;

        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 1'b0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(MEM_UNITS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_amount = i_data.amount;
                    if (i_data.operation == OP_RELEASE) begin
                        n_ptr      = LW'(i_data.position);
                        n_cnt      = '0;
                        n_fill_bit = 1'b0;
                        n_found    = 1'b1;
                        n_start    = i_data.position;
                        n_state    = ST_FILL;
                    end else if (i_data.amount == '0) begin
                        n_found = 1'b0;
                        n_start = '0;
                        n_state = ST_OUT;
                    end else begin
                        w_ctl.start  = 1'b1;
                        n_idx        = '0;
                        n_issue_done = 1'b0;
                        n_pv         = 1'b0;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!r_issue_done) begin
                    n_pv    = 1'b1;
                    n_pidx  = r_idx;
                    n_pterm = (r_idx == w_units);
                    if (r_idx == w_units) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end else begin
                    n_pv = 1'b0;
                end
                w_ctl.valid = r_pv;
                if (r_pv && (r_pterm || w_sts.stop)) begin
                    n_pv    = 1'b0;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (w_sts.have) begin
                    n_ptr      = LW'(w_best_start);
                    n_cnt      = '0;
                    n_fill_bit = 1'b1;
                    n_found    = 1'b1;
                    n_start    = 10'(w_best_start);
                    n_state    = ST_FILL;
                end else begin
                    n_found = 1'b0;
                    n_start = '0;
                    n_state = ST_OUT;
                end
            end
            ST_FILL: begin
                if ((r_cnt < r_amount) && (r_ptr < LW'(w_units))) begin
                    w_we  = 1'b1;
                    n_ptr = r_ptr + LW'(1);
                    n_cnt = r_cnt + 11'd1;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = (r_state == ST_OUT);
    assign o_data.found     = r_found;
    assign o_data.start_res = r_start;

    a_no_fit_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.found |-> o_data.start_res == '0)
        else $error("failed allocate returned nonzero start");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we && (r_state == ST_FILL) |-> r_ptr < LW'(w_units))
        else $error("map write beyond units in use");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("ready right after a request transfer");

    a_mark_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) && w_sts.have |=> (r_state == ST_FILL) && r_fill_bit)
        else $error("found run not marked occupied");

endmodule
`default_nettype wire

// File: sv/cfa_regs.sv
// Configuration registers of the allocator behind an APB-style port.
`default_nettype none
module cfa_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cfa_pkg::CFG_AW-1:0] paddr,
    input  wire logic [cfa_pkg::CFG_DW-1:0] pwdata,
    output logic      [cfa_pkg::CFG_DW-1:0] prdata,
    output logic                            pready,
    output logic      [1:0]                 o_fit_mode,
    output logic      [10:0]                o_mem_size
);
    import cfa_pkg::*;

    logic [1:0]  r_fit_mode;
    logic [10:0] r_mem_size;
    logic        w_wr;
    logic        w_idx;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= FIT_FIRST;
            r_mem_size <= MEM_SIZE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_FIT_MODE: r_fit_mode <= pwdata[1:0];
                REG_MEM_SIZE: r_mem_size <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FIT_MODE: prdata = CFG_DW'(r_fit_mode);
            REG_MEM_SIZE: prdata = CFG_DW'(r_mem_size);
            default:      prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign o_fit_mode = r_fit_mode;
    assign o_mem_size = r_mem_size;

endmodule
`default_nettype wire

// File: sv/cfa_map.sv
// Occupancy map memory: one bit per unit, one write and one registered read port.
`default_nettype none
module cfa_map #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic               o_rdata
);
    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: sv/cfa_run.sv
// Free run tracker and fit comparator, stepped one map unit per cycle while i_ctl.valid is high.
`default_nettype none
module cfa_run #(
    parameter int CW = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cfa_pkg::t_run_ctl i_ctl,
    input  wire logic [CW-1:0]     i_idx,
    input  wire logic [10:0]       i_amount,
    input  wire logic [1:0]        i_mode,
    output cfa_pkg::t_run_sts      o_sts,
    output logic      [CW-1:0]     o_best_start
);
    import cfa_pkg::*;

    localparam int LW = (CW > 11) ? CW : 11;

    logic [CW-1:0] r_run_start, n_run_start;
    logic [CW-1:0] r_run_len,   n_run_len;
    logic [CW-1:0] r_best_start, n_best_start;
    logic [CW-1:0] r_best_len,  n_best_len;
    logic          r_have,      n_have;
    logic          w_adequate;
    logic          w_take;
    logic          w_first;

    assign w_adequate = LW'(r_run_len) >= LW'(i_amount);
    assign w_first    = (i_mode != FIT_BEST) && (i_mode != FIT_WORST);
    assign w_take     = !r_have
                     || ((i_mode == FIT_BEST)  && (r_run_len < r_best_len))
                     || ((i_mode == FIT_WORST) && (r_run_len > r_best_len));

    always_comb begin
        n_run_start  = r_run_start;
        n_run_len    = r_run_len;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_have       = r_have;
        if (i_ctl.start) begin
            n_run_len = '0;
            n_have    = 1'b0;
        end else if (i_ctl.valid) begin
            if (i_ctl.is_free) begin
                if (r_run_len == '0) begin
                    n_run_start = i_idx;
                end
                n_run_len = r_run_len + CW'(1);
            end else begin
                if (w_adequate && w_take) begin
                    n_have       = 1'b1;
                    n_best_start = r_run_start;
                    n_best_len   = r_run_len;
                end
                n_run_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len <= '0;
            r_have    <= 1'b0;
        end else begin
            r_run_len <= n_run_len;
            r_have    <= n_have;
        end
        r_run_start  <= n_run_start;
        r_best_start <= n_best_start;
        r_best_len   <= n_best_len;
    end

    assign o_sts.have  = r_have;
    assign o_sts.stop  = i_ctl.valid && !i_ctl.is_free && w_adequate && w_first;
    assign o_best_start = r_best_start;

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the contiguous fit allocator.
`timescale 1ns / 1ps
module testbench;
    import cfa_pkg::*;

    localparam int UNITS = 1024;
    localparam logic [1:0] FIT_UNUSED = 2'd3;
    localparam int N_PHASES = 9;

    class fit_scoreboard;
        bit [UNITS-1:0] occupied;
        logic [1:0]     mode;
        logic [10:0]    size;
        t_out_item      placement_q[$];
        int             errors;
        int             n_placed;
        int             n_refused;
        int             n_released;
        int             n_settings;

        function new();
            occupied = '0;
            mode = FIT_FIRST;
            size = MEM_SIZE_RESET;
        endfunction

        function void set_register(logic idx, logic [CFG_DW-1:0] value);
            if (idx == REG_FIT_MODE) begin
                mode = value[1:0];
            end else begin
                size = value[10:0];
            end
            n_settings++;
        endfunction

        function int pending();
            return placement_q.size();
        endfunction

        function t_out_item predict_placement(t_in_item req);
            t_out_item r;
            int n;
            int amt;
            int pos;
            int run_start;
            int run_len;
            int best_start;
            int best_len;
            bit have;
            bit unit_free;
            r = '0;
            n = (size > UNITS) ? UNITS : int'(size);
            amt = int'(req.amount);
            pos = int'(req.position);
            if (req.operation == OP_RELEASE) begin
                for (int i = 0; i < amt; i++) begin
                    if (pos + i >= n) break;
                    occupied[pos + i] = 1'b0;
                end
                r.found = 1'b1;
                r.start_res = req.position;
                return r;
            end
            if (amt == 0) return r;
            have = 1'b0;
            run_start = 0;
            run_len = 0;
            best_start = 0;
            best_len = 0;
            for (int i = 0; i <= n; i++) begin
                unit_free = (i < n) && !occupied[i];
                if (unit_free) begin
                    if (run_len == 0) run_start = i;
                    run_len++;
                    continue;
                end
                if (run_len >= amt) begin
                    if (!have) begin
                        have = 1'b1;
                        best_start = run_start;
                        best_len = run_len;
                    end else if (mode == FIT_BEST && run_len < best_len) begin
                        best_start = run_start;
                        best_len = run_len;
                    end else if (mode == FIT_WORST && run_len > best_len) begin
                        best_start = run_start;
                        best_len = run_len;
                    end
                    if (mode != FIT_BEST && mode != FIT_WORST) break;
                end
                run_len = 0;
            end
            if (!have) return r;
            for (int i = 0; i < amt && best_start + i < n; i++) begin
                occupied[best_start + i] = 1'b1;
            end
            r.found = 1'b1;
            r.start_res = best_start[9:0];
            return r;
        endfunction

        function t_out_item note_request(t_in_item req);
            t_out_item r;
            r = predict_placement(req);
            placement_q.push_back(r);
            if (req.operation == OP_RELEASE) n_released++;
            else if (r.found) n_placed++;
            else n_refused++;
            return r;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch %0d: %s", $time, errors, msg);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (placement_q.size() == 0) begin
                report_mismatch($sformatf("result found=%0d start=%0d with nothing pending",
                                          got.found, got.start_res));
                return;
            end
            want = placement_q.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0d, want %0d", got.found, want.found));
            if (got.start_res !== want.start_res)
                report_mismatch($sformatf("start_res %0d, want %0d",
                                          got.start_res, want.start_res));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_in_item            i_data;
    logic                o_valid;
    logic                i_stall;
    t_out_item           o_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [CFG_DW-1:0]   pwdata;
    logic [CFG_DW-1:0]   prdata;
    logic                pready;

    fit_scoreboard sb;
    bit  idle_en;
    int  hold_left;
    int  live_start[$];
    int  live_len[$];

    logic [1:0] phase_mode [N_PHASES] = '{FIT_BEST, FIT_WORST, FIT_FIRST, FIT_UNUSED,
                                          FIT_WORST, FIT_BEST, FIT_FIRST, FIT_BEST,
                                          FIT_FIRST};
    int phase_size  [N_PHASES] = '{64, 32, 1024, 48, 1024, 2047, 0, 1, 128};
    int phase_count [N_PHASES] = '{120, 100, 40, 60, 30, 30, 20, 30, 130};

    contiguous_fit_allocator #(.MEM_UNITS(UNITS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("FAIL contiguous_fit_allocator");
        $finish;
    end

    // result side: random stall, long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= idle_en && ($urandom_range(99) < 27);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    function automatic t_in_item make_req(logic op, int amt, int pos);
        t_in_item r;
        r.operation = op;
        r.amount = amt[10:0];
        r.position = pos[9:0];
        return r;
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_DW-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic offer_request(input t_in_item req, output t_out_item predicted);
        @(negedge i_clk);
        if (idle_en && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        do @(posedge i_clk); while (o_stall);
        predicted = sb.note_request(req);
    endtask

    task automatic send(logic op, int amt, int pos);
        t_out_item ignored;
        offer_request(make_req(op, amt, pos), ignored);
    endtask

    task automatic await_all_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int count);
        t_in_item  req;
        t_out_item got;
        int n;
        int r;
        int pick;
        for (int k = 0; k < count; k++) begin
            n = (sb.size > UNITS) ? UNITS : int'(sb.size);
            r = $urandom_range(99);
            if (r < 50 || (r < 85 && live_start.size() == 0)) begin
                req.operation = OP_ALLOC;
                if ($urandom_range(9) == 0)
                    req.amount = 11'($urandom_range(0, 2047));
                else
                    req.amount = 11'($urandom_range(1, (n / 4 > 1) ? n / 4 : 1));
                req.position = 10'($urandom_range(0, 1023));
            end else if (r < 85) begin
                pick = $urandom_range(0, live_start.size() - 1);
                req = make_req(OP_RELEASE, live_len[pick], live_start[pick]);
                live_start.delete(pick);
                live_len.delete(pick);
            end else begin
                req.operation = OP_RELEASE;
                req.position = 10'($urandom_range(0, 1023));
                if ($urandom_range(1) == 0)
                    req.amount = 11'($urandom_range(0, 2047));
                else
                    req.amount = 11'($urandom_range(0, 16));
            end
            offer_request(req, got);
            if (req.operation == OP_ALLOC && got.found) begin
                live_start.push_back(int'(got.start_res));
                live_len.push_back(int'(req.amount));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_en = 1'b1;
        hold_left = 0;
        sb = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(REG_FIT_MODE, 32'(FIT_FIRST));
        write_reg(REG_MEM_SIZE, 32'(MEM_SIZE_RESET));
        send(OP_ALLOC, 0, 1023);
        send(OP_ALLOC, 1, 0);
        send(OP_ALLOC, 1024, 0);
        send(OP_ALLOC, 2047, 1023);
        send(OP_RELEASE, 2047, 0);
        send(OP_ALLOC, 1024, 0);
        send(OP_ALLOC, 1, 0);
        send(OP_RELEASE, 1, 1023);
        send(OP_ALLOC, 1, 0);
        send(OP_RELEASE, 2047, 1023);
        send(OP_RELEASE, 0, 0);
        send(OP_RELEASE, 50, 100);
        send(OP_RELEASE, 10, 300);
        send(OP_RELEASE, 400, 500);
        send(OP_ALLOC, 8, 0);
        await_all_results();
        write_reg(REG_FIT_MODE, 32'(FIT_BEST));
        send(OP_ALLOC, 5, 0);
        await_all_results();
        write_reg(REG_FIT_MODE, 32'(FIT_WORST));
        send(OP_ALLOC, 5, 0);
        await_all_results();
        write_reg(REG_FIT_MODE, 32'(FIT_UNUSED));
        send(OP_ALLOC, 2, 0);

        for (int p = 0; p < N_PHASES; p++) begin
            await_all_results();
            write_reg(REG_FIT_MODE, 32'(phase_mode[p]));
            write_reg(REG_MEM_SIZE, 32'(phase_size[p]));
            live_start.delete();
            live_len.delete();
            idle_en = (p != 1);
            if (p == 0) hold_left = 300;
            run_phase(phase_count[p]);
        end

        await_all_results();
        repeat (20) @(posedge i_clk);
        if (sb.pending() != 0) sb.report_mismatch("results still pending at end of run");
        $display("%0d requests: %0d placed, %0d refused, %0d releases, %0d register writes",
                 sb.n_placed + sb.n_refused + sb.n_released, sb.n_placed, sb.n_refused,
                 sb.n_released, sb.n_settings);
        $display("all four fit modes, memory sizes 0 to 2047, long output hold-off, drains");
        if (sb.errors == 0) begin
            $display("PASS contiguous_fit_allocator");
        end else begin
            $display("FAIL contiguous_fit_allocator");
        end
        $finish;
    end
endmodule
